[design/mrs_pkg.sv]
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types, codes and the CRC-16 byte step for the RTU register server.
// ----------------------------------------------------------------------------
package mrs_pkg;

  // sizes
  localparam int INPUT_REGS_MAX   = 16;
  localparam int HOLDING_REGS_MAX = 16;
  localparam int FRAME_BYTES_MAX  = 256;
  localparam int FB_AW            = $clog2(FRAME_BYTES_MAX);
  localparam int LEN_W            = FB_AW + 1;
  localparam int IN_AW            = $clog2(INPUT_REGS_MAX);
  localparam int HOLD_AW          = $clog2(HOLDING_REGS_MAX);
  localparam int CNT_W            = 5;
  localparam int RI_W             = 7;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // input operations
  localparam logic [1:0] OP_RX_BYTE  = 2'd0;
  localparam logic [1:0] OP_WR_INPUT = 2'd1;
  localparam logic [1:0] OP_WR_HOLD  = 2'd2;
  localparam logic [1:0] OP_RD_HOLD  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_TX_BYTE = 2'd0;
  localparam logic [1:0] KIND_HOST    = 2'd1;
  localparam logic [1:0] KIND_FRAME   = 2'd2;

  // frame outcomes
  localparam logic [1:0] FST_HANDLED = 2'd0;
  localparam logic [1:0] FST_SHORT   = 2'd1;
  localparam logic [1:0] FST_CRC     = 2'd2;
  localparam logic [1:0] FST_ADDR    = 2'd3;

  // host answers
  localparam logic HST_OK    = 1'b0;
  localparam logic HST_RANGE = 1'b1;

  // function codes
  localparam logic [7:0] FN_READ_COILS    = 8'd1;
  localparam logic [7:0] FN_READ_DISCRETE = 8'd2;
  localparam logic [7:0] FN_READ_HOLD     = 8'd3;
  localparam logic [7:0] FN_READ_INPUT    = 8'd4;
  localparam logic [7:0] FN_WRITE_COIL    = 8'd5;
  localparam logic [7:0] FN_WRITE_SINGLE  = 8'd6;
  localparam logic [7:0] FN_WRITE_COILS   = 8'd15;
  localparam logic [7:0] FN_WRITE_MULTI   = 8'd16;
  localparam logic [7:0] FN_EXC_FLAG      = 8'h80;

  localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'd1;
  localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SLAVE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_INPUT_COUNT   = 2'd1;
  localparam logic [1:0] REG_HOLD_COUNT    = 2'd2;

  // back end sequencer
  typedef enum logic [2:0] {
    B_IDLE, B_SWEEP, B_CHECK, B_WRITE, B_REPLY, B_STATUS
  } back_state_t;

  typedef enum logic [2:0] {
    M_NONE, M_EXC, M_READ, M_ECHO, M_WR16
  } reply_mode_t;

  // word from front to back
  typedef struct packed {
    logic             frame;
    logic [1:0]       op;
    logic [7:0]       idx;
    logic [15:0]      val;
    logic [LEN_W-1:0] len;
  } cmd_t;

  // one result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [1:0]  frame_status;
    logic        host_status;
    logic [15:0] host_data;
  } res_t;

  // frame finished, back to front
  typedef struct packed {
    logic valid;
    logic clear;
  } done_t;

  // live configuration, counts already clipped to bank size
  typedef struct packed {
    logic [7:0]       slave_address;
    logic [CNT_W-1:0] in_count;
    logic [CNT_W-1:0] hold_count;
  } cfg_t;

  // one byte of the reflected CRC-16
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[design/mrs_ram.sv]
// ----------------------------------------------------------------------------
// mrs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/mrs_front.sv]
// ----------------------------------------------------------------------------
// mrs_front
// Accepts input words, stores received bytes, keeps the frame length and
// queues host operations and frame ends for the back end.
// ----------------------------------------------------------------------------
module mrs_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                op,
  input  logic [7:0]                rx_byte,
  input  logic                      frame_end,
  input  logic [7:0]                reg_index,
  input  logic [15:0]               reg_value,
  output logic                      ram_we,
  output logic [mrs_pkg::FB_AW-1:0] ram_waddr,
  output logic [7:0]                ram_wdata,
  output logic                      cmd_valid,
  output mrs_pkg::cmd_t             cmd,
  input  logic                      cmd_pop,
  input  mrs_pkg::done_t            done
);
  import mrs_pkg::*;

  logic [LEN_W-1:0] frame_length;
  logic             busy;
  cmd_t             q_mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       q_count;

  logic             accept;
  logic             is_rx;
  logic             len_room;
  logic [LEN_W-1:0] len_after;
  logic             cmd_push;
  cmd_t             new_cmd;

  // classify the incoming word
  always_comb begin
    full      = busy || (q_count == 2'd2);
    accept    = push && !full;
    is_rx     = (op == OP_RX_BYTE);
    len_room  = frame_length < LEN_W'(FRAME_BYTES_MAX);
    ram_we    = accept && is_rx && len_room;
    ram_waddr = frame_length[FB_AW-1:0];
    ram_wdata = rx_byte;
    len_after = len_room ? frame_length + LEN_W'(1) : frame_length;
    cmd_push  = accept && (!is_rx || frame_end);
    new_cmd.frame = is_rx;
    new_cmd.op    = op;
    new_cmd.idx   = reg_index;
    new_cmd.val   = reg_value;
    new_cmd.len   = len_after;
    cmd_valid = (q_count != 2'd0);
    cmd       = q_mem[rd_ptr];
  end

  // frame length and frame-in-progress flag
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= '0;
      busy         <= 1'b0;
    end else begin
      if (done.valid && done.clear) begin
        frame_length <= '0;
      end else if (ram_we) begin
        frame_length <= len_after;
      end
      if (done.valid) begin
        busy <= 1'b0;
      end else if (cmd_push && is_rx) begin
        busy <= 1'b1;
      end
    end
  end

  // two-word queue to the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= '0;
    end else begin
      if (cmd_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      q_count <= q_count + {1'b0, cmd_push} - {1'b0, cmd_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_push) begin
      q_mem[wr_ptr] <= new_cmd;
    end
  end

endmodule

[design/mrs_back.sv]
// ----------------------------------------------------------------------------
// mrs_back
// Executes queued words: host register access, and at frame end the CRC
// sweep, request decode, register writes and byte-wise reply with CRC.
// ----------------------------------------------------------------------------
module mrs_back (
  input  logic                      clk,
  input  logic                      rst,
  input  mrs_pkg::cfg_t             cfg,
  input  logic                      cmd_valid,
  input  mrs_pkg::cmd_t             cmd,
  output logic                      cmd_pop,
  output logic [mrs_pkg::FB_AW-1:0] ram_raddr,
  input  logic [7:0]                ram_rdata,
  output mrs_pkg::done_t            done,
  output logic                      empty,
  input  logic                      pop,
  output mrs_pkg::res_t             res
);
  import mrs_pkg::*;

  back_state_t      state, state_next;
  reply_mode_t      mode;
  logic [LEN_W-1:0] frame_len;
  logic [LEN_W-1:0] addr_cnt;
  logic [LEN_W-1:0] wr_end;
  logic             rd_v;
  logic [LEN_W-1:0] rd_idx;
  logic [15:0]      crc;
  logic [7:0]       hdr [6];
  logic [15:0]      got;
  logic [1:0]       fstatus;
  logic             fclear;
  logic [7:0]       exc_code;
  logic [RI_W-1:0]  ri;
  logic [RI_W-1:0]  rlen;
  logic [7:0]       wr_hi;
  logic [15:0]      input_bank [INPUT_REGS_MAX];
  logic [15:0]      holding_bank [HOLDING_REGS_MAX];

  res_t             oq [2];
  logic             oq_wr;
  logic             oq_rd;
  logic [1:0]       oq_count;

  logic             can_emit;
  logic             emit;
  res_t             emit_res;
  logic             issue;

  logic [7:0]       func;
  logic [15:0]      start;
  logic [15:0]      qty;
  logic [16:0]      sum;
  logic [CNT_W-1:0] cnt_rd;
  reply_mode_t      dec_mode;
  logic [7:0]       dec_code;
  logic [RI_W-1:0]  dec_rlen;
  logic [7:0]       rd_data;
  logic [RI_W-1:0]  rk;
  logic [IN_AW-1:0]   rd_in_idx;
  logic [HOLD_AW-1:0] rd_hold_idx;
  logic [15:0]      rd_word;
  logic [7:0]       reply_byte;
  logic [LEN_W-1:0] wr_off;
  logic [HOLD_AW-1:0] wr_idx;
  logic             host_in_ok;
  logic             host_hold_ok;
  res_t             host_res;

  // request fields and decode
  always_comb begin
    func   = hdr[1];
    start  = {hdr[2], hdr[3]};
    qty    = {hdr[4], hdr[5]};
    sum    = {1'b0, start} + {1'b0, qty};
    cnt_rd = (func == FN_READ_INPUT) ? cfg.in_count : cfg.hold_count;
    dec_mode = M_NONE;
    dec_code = EXC_ILLEGAL_ADDR;
    if (func == FN_READ_HOLD || func == FN_READ_INPUT) begin
      dec_mode = (sum > 17'(cnt_rd)) ? M_EXC : M_READ;
    end else if (func == FN_WRITE_SINGLE) begin
      dec_mode = (start >= 16'(cfg.hold_count)) ? M_EXC : M_ECHO;
    end else if (func == FN_WRITE_MULTI) begin
      dec_mode = (sum > 17'(cfg.hold_count)) ? M_EXC : M_WR16;
    end else if (func == FN_READ_COILS || func == FN_READ_DISCRETE ||
                 func == FN_WRITE_COIL || func == FN_WRITE_COILS) begin
      dec_mode = M_EXC;
      dec_code = EXC_ILLEGAL_FUNC;
    end
    unique case (dec_mode)
      M_READ:  dec_rlen = RI_W'(3) + RI_W'({qty[4:0], 1'b0});
      M_EXC:   dec_rlen = RI_W'(3);
      default: dec_rlen = RI_W'(6);
    endcase
  end

  // reply byte generator
  always_comb begin
    rd_data     = (rd_idx < frame_len) ? ram_rdata : 8'h00;
    rk          = ri - RI_W'(3);
    rd_in_idx   = start[IN_AW-1:0] + rk[IN_AW:1];
    rd_hold_idx = start[HOLD_AW-1:0] + rk[HOLD_AW:1];
    rd_word     = (func == FN_READ_INPUT) ? input_bank[rd_in_idx] : holding_bank[rd_hold_idx];
    if (ri < rlen) begin
      if (ri == RI_W'(0)) begin
        reply_byte = cfg.slave_address;
      end else if (ri == RI_W'(1)) begin
        reply_byte = (mode == M_EXC) ? (func | FN_EXC_FLAG) : func;
      end else if (mode == M_EXC) begin
        reply_byte = exc_code;
      end else if (mode == M_READ) begin
        if (ri == RI_W'(2)) begin
          reply_byte = {qty[6:0], 1'b0};
        end else begin
          reply_byte = rk[0] ? rd_word[7:0] : rd_word[15:8];
        end
      end else begin
        reply_byte = hdr[ri[2:0]];
      end
    end else if (ri == rlen) begin
      reply_byte = crc[7:0];
    end else begin
      reply_byte = crc[15:8];
    end
    wr_off = rd_idx - LEN_W'(7);
    wr_idx = start[HOLD_AW-1:0] + wr_off[HOLD_AW:1];
  end

  // host answer
  always_comb begin
    host_in_ok   = cmd.idx < 8'(cfg.in_count);
    host_hold_ok = cmd.idx < 8'(cfg.hold_count);
    host_res     = '0;
    host_res.kind    = KIND_HOST;
    host_res.tx_last = 1'b1;
    unique case (cmd.op)
      OP_WR_INPUT: host_res.host_status = host_in_ok ? HST_OK : HST_RANGE;
      OP_RD_HOLD: begin
        host_res.host_status = host_hold_ok ? HST_OK : HST_RANGE;
        host_res.host_data   = host_hold_ok ? holding_bank[cmd.idx[HOLD_AW-1:0]] : 16'h0000;
      end
      default:    host_res.host_status = host_hold_ok ? HST_OK : HST_RANGE;
    endcase
  end

  // sequencer: next state and handshakes
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    emit       = 1'b0;
    emit_res   = '0;
    done       = '0;
    issue      = 1'b0;
    can_emit   = (oq_count != 2'd2);
    ram_raddr  = addr_cnt[FB_AW-1:0];
    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          if (cmd.frame) begin
            cmd_pop    = 1'b1;
            state_next = (cmd.len < LEN_W'(2)) ? B_STATUS : B_SWEEP;
          end else if (can_emit) begin
            cmd_pop  = 1'b1;
            emit     = 1'b1;
            emit_res = host_res;
          end
        end
      end
      B_SWEEP: begin
        issue = (addr_cnt != frame_len);
        if (!issue && !rd_v) begin
          state_next = B_CHECK;
        end
      end
      B_CHECK: begin
        priority if (crc != got) begin
          state_next = B_STATUS;
        end else if (hdr[0] != cfg.slave_address) begin
          state_next = B_STATUS;
        end else if (dec_mode == M_WR16) begin
          state_next = B_WRITE;
        end else if (dec_mode == M_NONE) begin
          state_next = B_STATUS;
        end else begin
          state_next = B_REPLY;
        end
      end
      B_WRITE: begin
        issue = (addr_cnt != wr_end);
        if (!issue && !rd_v) begin
          state_next = B_REPLY;
        end
      end
      B_REPLY: begin
        if (can_emit) begin
          emit             = 1'b1;
          emit_res.kind    = KIND_TX_BYTE;
          emit_res.tx_byte = reply_byte;
          if (ri == rlen + RI_W'(1)) begin
            state_next = B_STATUS;
          end
        end
      end
      B_STATUS: begin
        if (can_emit) begin
          emit                  = 1'b1;
          emit_res.kind         = KIND_FRAME;
          emit_res.tx_last      = 1'b1;
          emit_res.frame_status = fstatus;
          done.valid            = 1'b1;
          done.clear            = fclear;
          state_next            = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // read pipeline tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= issue;
    end
  end

  // register banks
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < INPUT_REGS_MAX; i++) begin
        input_bank[i] <= '0;
      end
      for (int i = 0; i < HOLDING_REGS_MAX; i++) begin
        holding_bank[i] <= '0;
      end
    end else begin
      if (state == B_IDLE && cmd_pop && !cmd.frame) begin
        if (cmd.op == OP_WR_INPUT && host_in_ok) begin
          input_bank[cmd.idx[IN_AW-1:0]] <= cmd.val;
        end
        if (cmd.op == OP_WR_HOLD && host_hold_ok) begin
          holding_bank[cmd.idx[HOLD_AW-1:0]] <= cmd.val;
        end
      end
      if (state == B_CHECK && crc == got && hdr[0] == cfg.slave_address &&
          func == FN_WRITE_SINGLE && dec_mode == M_ECHO) begin
        holding_bank[start[HOLD_AW-1:0]] <= qty;
      end
      if (state == B_WRITE && rd_v && wr_off[0]) begin
        holding_bank[wr_idx] <= {wr_hi, rd_data};
      end
    end
  end

  // frame datapath
  always_ff @(posedge clk) begin
    if (issue) begin
      addr_cnt <= addr_cnt + LEN_W'(1);
      rd_idx   <= addr_cnt;
    end
    unique case (state)
      B_IDLE: begin
        frame_len <= cmd.len;
        addr_cnt  <= '0;
        crc       <= CRC_INIT;
        got       <= '0;
        fstatus   <= FST_SHORT;
        fclear    <= 1'b0;
        for (int i = 0; i < 6; i++) begin
          hdr[i] <= 8'h00;
        end
      end
      B_SWEEP: begin
        if (rd_v) begin
          if (rd_idx < frame_len - LEN_W'(2)) begin
            crc <= crc_byte(crc, ram_rdata);
          end
          if (rd_idx < LEN_W'(6)) begin
            hdr[rd_idx[2:0]] <= ram_rdata;
          end
          if (rd_idx == frame_len - LEN_W'(2)) begin
            got[7:0] <= ram_rdata;
          end
          if (rd_idx == frame_len - LEN_W'(1)) begin
            got[15:8] <= ram_rdata;
          end
        end
      end
      B_CHECK: begin
        ri       <= '0;
        crc      <= CRC_INIT;
        rlen     <= dec_rlen;
        exc_code <= dec_code;
        mode     <= (dec_mode == M_WR16) ? M_ECHO : dec_mode;
        addr_cnt <= LEN_W'(7);
        wr_end   <= LEN_W'(7) + LEN_W'({qty[4:0], 1'b0});
        priority if (crc != got) begin
          fstatus <= FST_CRC;
          fclear  <= 1'b1;
        end else if (hdr[0] != cfg.slave_address) begin
          fstatus <= FST_ADDR;
          fclear  <= 1'b0;
        end else begin
          fstatus <= FST_HANDLED;
          fclear  <= 1'b1;
        end
      end
      B_WRITE: begin
        if (rd_v && !wr_off[0]) begin
          wr_hi <= rd_data;
        end
      end
      B_REPLY: begin
        if (emit) begin
          ri <= ri + RI_W'(1);
          if (ri < rlen) begin
            crc <= crc_byte(crc, reply_byte);
          end
        end
      end
      default: ;
    endcase
  end

  // result queue
  always_comb begin
    empty = (oq_count == 2'd0);
    res   = oq[oq_rd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= 1'b0;
      oq_rd    <= 1'b0;
      oq_count <= '0;
    end else begin
      if (emit) begin
        oq_wr <= ~oq_wr;
      end
      if (pop && !empty) begin
        oq_rd <= ~oq_rd;
      end
      oq_count <= oq_count + {1'b0, emit} - {1'b0, pop && !empty};
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oq[oq_wr] <= emit_res;
    end
  end

  // checks
  a_oq_bound: assert property (@(posedge clk) disable iff (rst) oq_count <= 2'd2)
    else $error("result queue overfilled");
  a_emit_room: assert property (@(posedge clk) disable iff (rst) emit |-> oq_count != 2'd2)
    else $error("result written into full queue");
  a_drained: assert property (@(posedge clk) disable iff (rst)
      (state == B_CHECK || state == B_REPLY) |-> !rd_v)
    else $error("frame read still in flight");
  a_reply_end: assert property (@(posedge clk) disable iff (rst)
      (state == B_REPLY) |-> (ri <= rlen + RI_W'(1)))
    else $error("reply index ran past end");

endmodule

[design/modbus_rtu_slave_register_server.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_slave_register_server
// RTU slave: collects request bytes, checks and serves frames on the input
// and holding banks, and answers host register operations.
// ----------------------------------------------------------------------------
//  channel  | handshake          | words
//  input    | push / full        | op, rx_byte, frame_end, reg_index, reg_value
//  result   | empty / pop        | kind, tx_byte, tx_last, frame_status,
//           |                    | host_status, host_data
//  config   | cfg_write          | cfg_index, cfg_data
//
// A received byte that does not end a frame is stored in the frame RAM. A
// host word goes through a two-word queue and leaves one result. A frame end
// holds full high until its frame status is queued: the frame bytes are swept
// through the frame RAM read port at one a cycle, function 16 writes its
// registers from the frame, and reply bytes including CRC are emitted one a
// cycle while the result queue has room; a too-short frame skips to status.
// Reset clears lengths, banks and queues; the frame RAM needs no clearing.
// A stalled result side holds the back end, which in turn fills the queue.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_register_server (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op,
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  input  logic [7:0]  reg_index,
  input  logic [15:0] reg_value,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  tx_byte,
  output logic        tx_last,
  output logic [1:0]  frame_status,
  output logic        host_status,
  output logic [15:0] host_data,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import mrs_pkg::*;

  logic [7:0]       slave_address;
  logic [CNT_W-1:0] input_reg_count;
  logic [CNT_W-1:0] holding_reg_count;
  cfg_t             cfg;

  logic             ram_we;
  logic [FB_AW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [FB_AW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;
  done_t            done;
  res_t             res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address     <= 8'd1;
      input_reg_count   <= CNT_W'(INPUT_REGS_MAX);
      holding_reg_count <= CNT_W'(HOLDING_REGS_MAX);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SLAVE_ADDRESS: slave_address     <= cfg_data;
        REG_INPUT_COUNT:   input_reg_count   <= cfg_data[CNT_W-1:0];
        REG_HOLD_COUNT:    holding_reg_count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // counts above the bank size act as the bank size
  always_comb begin
    cfg.slave_address = slave_address;
    cfg.in_count   = (input_reg_count > CNT_W'(INPUT_REGS_MAX)) ?
                     CNT_W'(INPUT_REGS_MAX) : input_reg_count;
    cfg.hold_count = (holding_reg_count > CNT_W'(HOLDING_REGS_MAX)) ?
                     CNT_W'(HOLDING_REGS_MAX) : holding_reg_count;
    kind         = res.kind;
    tx_byte      = res.tx_byte;
    tx_last      = res.tx_last;
    frame_status = res.frame_status;
    host_status  = res.host_status;
    host_data    = res.host_data;
  end

  mrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .op        (op),
    .rx_byte   (rx_byte),
    .frame_end (frame_end),
    .reg_index (reg_index),
    .reg_value (reg_value),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .done      (done)
  );

  mrs_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES_MAX)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mrs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .done      (done),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

endmodule
